@@ design/local_interrupt_controller_timer_top_defines.svh @@
// Assertion macros for the timer top design file.
`ifndef LOCAL_INTERRUPT_CONTROLLER_TIMER_TOP_DEFINES_SVH
`define LOCAL_INTERRUPT_CONTROLLER_TIMER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LICT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LICT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/lict_pkg.sv @@
package lict_pkg;

  localparam int WORD_W   = 32;
  localparam int IDX_W    = 6;
  localparam int OP_W     = 2;
  localparam int VEC_W    = 8;
  localparam int MODE_W   = 2;
  localparam int DIV_W    = 3;
  localparam int PRE_W    = 7;
  localparam int MASK_BIT = 16;
  localparam int MODE_LSB = 17;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [VEC_W-1:0]  vec_t;
  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [DIV_W-1:0]  div_code_t;
  typedef logic [PRE_W-1:0]  pre_t;

  localparam op_t OP_READ  = 2'd0;
  localparam op_t OP_WRITE = 2'd1;
  localparam op_t OP_TICK  = 2'd2;

  localparam idx_t IDX_VECTOR  = 6'h32;
  localparam idx_t IDX_INITIAL = 6'h38;
  localparam idx_t IDX_CURRENT = 6'h39;
  localparam idx_t IDX_DIVIDE  = 6'h3E;

  localparam mode_t MODE_PERIODIC = 2'd1;

  // Last prescaler value before the count steps; code 7 divides by one.
  function automatic pre_t div_limit(input div_code_t code);
    pre_t lim;
    case (code)
      3'd0:    lim = 7'd1;
      3'd1:    lim = 7'd3;
      3'd2:    lim = 7'd7;
      3'd3:    lim = 7'd15;
      3'd4:    lim = 7'd31;
      3'd5:    lim = 7'd63;
      3'd6:    lim = 7'd127;
      default: lim = 7'd0;
    endcase
    return lim;
  endfunction

endpackage

@@ design/lict_in_if.sv @@
interface lict_in_if import lict_pkg::*; ();
  logic  valid;
  logic  ready;
  op_t   op;
  idx_t  reg_index;
  word_t write_data;

  modport source (output valid, output op, output reg_index, output write_data,
                  input ready);
  modport sink (input valid, input op, input reg_index, input write_data,
                output ready);
endinterface

@@ design/lict_out_if.sv @@
interface lict_out_if import lict_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t read_data;
  logic  irq_fire;
  vec_t  irq_vector;

  modport source (output valid, output read_data, output irq_fire,
                  output irq_vector, input ready);
  modport sink (input valid, input read_data, input irq_fire,
                input irq_vector, output ready);
endinterface

@@ design/local_interrupt_controller_timer_top.sv @@
// Local interrupt controller timer: one bus read, bus write, timer tick or no-op per word.
// Each result word is registered and presented in the cycle after its input word is accepted.
// Throughput is one word per cycle while out.ready holds; the output register frees while it is taken.
// Synchronous active-high reset masks the timer, clears counts and the prescaler,
// selects divide by two and empties the output register.
`include "local_interrupt_controller_timer_top_defines.svh"

module local_interrupt_controller_timer_top import lict_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input logic  clk,
  input logic  rst,
  lict_in_if.sink    in,
  lict_out_if.source out
);

  typedef logic [COUNT_WIDTH-1:0] count_t;

  vec_t      timer_vector, timer_vector_next;
  logic      timer_masked, timer_masked_next;
  mode_t     timer_mode, timer_mode_next;
  count_t    initial_count, initial_count_next;
  count_t    current_count, current_count_next;
  div_code_t divide_code, divide_code_next;
  pre_t      prescale_counter, prescale_counter_next;

  logic  out_valid;
  word_t out_read_data;
  logic  out_irq_fire;
  vec_t  out_irq_vector;

  word_t  rd_next;
  logic   fire_next;
  count_t dec_count;
  logic   in_accept;

  assign in.ready  = !out_valid || out.ready;
  assign in_accept = in.valid && in.ready;
  assign dec_count = current_count - count_t'(1);

  always_comb begin
    timer_vector_next     = timer_vector;
    timer_masked_next     = timer_masked;
    timer_mode_next       = timer_mode;
    initial_count_next    = initial_count;
    current_count_next    = current_count;
    divide_code_next      = divide_code;
    prescale_counter_next = prescale_counter;
    rd_next               = '0;
    fire_next             = 1'b0;
    case (in.op)
      OP_READ: begin
        case (in.reg_index)
          IDX_VECTOR: begin
            rd_next                           = '0;
            rd_next[VEC_W-1:0]                = timer_vector;
            rd_next[MASK_BIT]                 = timer_masked;
            rd_next[MODE_LSB+MODE_W-1:MODE_LSB] = timer_mode;
          end
          IDX_INITIAL: rd_next = WORD_W'(initial_count);
          IDX_CURRENT: rd_next = WORD_W'(current_count);
          IDX_DIVIDE: begin
            rd_next      = '0;
            rd_next[1:0] = divide_code[1:0];
            rd_next[3]   = divide_code[2];
          end
          default: rd_next = '0;
        endcase
      end
      OP_WRITE: begin
        case (in.reg_index)
          IDX_VECTOR: begin
            timer_vector_next = in.write_data[VEC_W-1:0];
            timer_masked_next = in.write_data[MASK_BIT];
            timer_mode_next   = in.write_data[MODE_LSB+MODE_W-1:MODE_LSB];
          end
          IDX_INITIAL: begin
            initial_count_next    = in.write_data[COUNT_WIDTH-1:0];
            current_count_next    = in.write_data[COUNT_WIDTH-1:0];
            prescale_counter_next = '0;
          end
          IDX_DIVIDE: begin
            divide_code_next      = {in.write_data[3], in.write_data[1:0]};
            prescale_counter_next = '0;
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        if (current_count == '0) begin
          prescale_counter_next = '0;
        end else if (prescale_counter != div_limit(divide_code)) begin
          prescale_counter_next = prescale_counter + pre_t'(1);
        end else begin
          prescale_counter_next = '0;
          if (dec_count == '0) begin
            fire_next          = !timer_masked;
            current_count_next = (timer_mode == MODE_PERIODIC) ? initial_count : '0;
          end else begin
            current_count_next = dec_count;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_vector     <= '0;
      timer_masked     <= 1'b1;
      timer_mode       <= '0;
      initial_count    <= '0;
      current_count    <= '0;
      divide_code      <= '0;
      prescale_counter <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (in_accept) begin
        timer_vector     <= timer_vector_next;
        timer_masked     <= timer_masked_next;
        timer_mode       <= timer_mode_next;
        initial_count    <= initial_count_next;
        current_count    <= current_count_next;
        divide_code      <= divide_code_next;
        prescale_counter <= prescale_counter_next;
        out_valid        <= 1'b1;
      end else if (out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_read_data  <= rd_next;
      out_irq_fire   <= fire_next;
      out_irq_vector <= fire_next ? timer_vector : '0;
    end
  end

  assign out.valid      = out_valid;
  assign out.read_data  = out_read_data;
  assign out.irq_fire   = out_irq_fire;
  assign out.irq_vector = out_irq_vector;

  `LICT_ASSERT_NOW(a_fire_no_read_data, clk, rst, out_valid && out_irq_fire,
    out_read_data == '0, "interrupt word carries read data")
  `LICT_ASSERT_NOW(a_stopped_prescaler_idle, clk, rst, current_count == '0,
    prescale_counter == '0, "prescaler runs while the timer is stopped")
  `LICT_ASSERT_NOW(a_prescaler_in_range, clk, rst, 1'b1,
    prescale_counter <= div_limit(divide_code), "prescaler beyond its divide limit")
  `LICT_ASSERT_NEXT(a_initial_load, clk, rst,
    in_accept && in.op == OP_WRITE && in.reg_index == IDX_INITIAL,
    current_count == $past(in.write_data[COUNT_WIDTH-1:0]),
    "initial count write did not load the current count")
  `LICT_ASSERT_NEXT(a_count_holds, clk, rst,
    in_accept && in.op != OP_TICK &&
    !(in.op == OP_WRITE && in.reg_index == IDX_INITIAL),
    $stable(current_count), "current count changed without a tick or load")

endmodule

@@ verif/local_interrupt_controller_timer_top_tb.sv @@
module local_interrupt_controller_timer_top_tb;
  import lict_pkg::*;

  localparam int COUNT_W = 32;
  localparam word_t CNT_MASK = word_t'((64'd1 << COUNT_W) - 1);
  localparam op_t OP_NONE = 2'd3;
  localparam mode_t MODE_ONESHOT = 2'd0;
  localparam int DIR_N = 26;
  localparam int WORDS_PER_PHASE = 331;
  localparam int LIMIT_CYCLES = 200000;

  typedef struct {
    op_t   op;
    idx_t  idx;
    word_t data;
    int    phase;
    bit    hold;
    bit    typed;
    word_t rd;
    logic  fire;
    vec_t  vec;
  } timer_word_t;

  typedef struct {
    word_t rd;
    logic  fire;
    vec_t  vec;
  } timer_resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lict_in_if  in_if();
  lict_out_if out_if();

  local_interrupt_controller_timer_top #(.COUNT_WIDTH(COUNT_W)) u_dut (
    .clk (clk),
    .rst (rst),
    .in  (in_if.sink),
    .out (out_if.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  timer_word_t dir_tbl [DIR_N];
  timer_word_t word_q [$];
  timer_resp_t resp_q [$];

  int send_pct [4] = '{0, 66, 0, 30};
  int recv_pct [4] = '{0, 0, 66, 30};
  int cur_phase = 0;
  bit hold_next = 1'b0;

  int err_cnt = 0;
  int n_checked = 0;
  int n_rd = 0;
  int n_wr = 0;
  int n_tk = 0;
  int n_other = 0;
  int n_irq = 0;

  vec_t      t_vector;
  logic      t_masked;
  mode_t     t_mode;
  word_t     t_initial;
  word_t     t_current;
  div_code_t t_div;
  pre_t      t_pre;

  function automatic bit coin(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic timer_word_t row(op_t op, idx_t idx, word_t data, bit typed,
                                      word_t rd, logic fire, vec_t vec);
    timer_word_t w;
    w.op = op;
    w.idx = idx;
    w.data = data;
    w.phase = 0;
    w.hold = 1'b0;
    w.typed = typed;
    w.rd = rd;
    w.fire = fire;
    w.vec = vec;
    return w;
  endfunction

  function automatic timer_resp_t timer_step(op_t op, idx_t idx, word_t data);
    timer_resp_t r;
    int unsigned div;
    r.rd = '0;
    r.fire = 1'b0;
    r.vec = '0;
    case (op)
      OP_READ: begin
        case (idx)
          IDX_VECTOR:  r.rd = {13'b0, t_mode, t_masked, 8'b0, t_vector};
          IDX_INITIAL: r.rd = t_initial;
          IDX_CURRENT: r.rd = t_current;
          IDX_DIVIDE:  r.rd = {28'b0, t_div[2], 1'b0, t_div[1:0]};
          default:     r.rd = '0;
        endcase
      end
      OP_WRITE: begin
        case (idx)
          IDX_VECTOR: begin
            t_vector = data[VEC_W-1:0];
            t_masked = data[MASK_BIT];
            t_mode = data[MODE_LSB +: MODE_W];
          end
          IDX_INITIAL: begin
            t_initial = data & CNT_MASK;
            t_current = t_initial;
            t_pre = '0;
          end
          IDX_DIVIDE: begin
            t_div = {data[3], data[1:0]};
            t_pre = '0;
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        if (t_current == '0) begin
          t_pre = '0;
        end else begin
          div = (t_div == 3'd7) ? 1 : (2 << t_div);
          if (t_pre + 1 < div) begin
            t_pre = t_pre + 1'b1;
          end else begin
            t_pre = '0;
            t_current = (t_current - 1) & CNT_MASK;
            if (t_current == '0) begin
              if (t_mode == MODE_PERIODIC) t_current = t_initial;
              r.fire = !t_masked;
            end
          end
        end
      end
      default: ;
    endcase
    if (r.fire) r.vec = t_vector;
    return r;
  endfunction

  task automatic add_word(op_t op, idx_t idx, word_t data, int ph);
    timer_word_t w;
    w = row(op, idx, data, 1'b0, '0, 1'b0, '0);
    w.phase = ph;
    w.hold = hold_next;
    hold_next = 1'b0;
    word_q.push_back(w);
  endtask

  task automatic add_setup(int ph, int which);
    word_t d;
    mode_t m;
    div_code_t c;
    int r;
    d = $urandom;
    r = $urandom_range(99);
    case (which)
      0: begin
        if (r < 60) m = MODE_PERIODIC;
        else if (r < 90) m = MODE_ONESHOT;
        else m = mode_t'($urandom_range(2, 3));
        d[MASK_BIT] = ($urandom_range(9) == 0);
        d[MODE_LSB +: MODE_W] = m;
        add_word(OP_WRITE, IDX_VECTOR, d, ph);
      end
      1: begin
        if (r < 40) c = 3'd7;
        else if (r < 70) c = 3'd0;
        else if (r < 85) c = 3'd1;
        else c = div_code_t'($urandom_range(7));
        d[1:0] = c[1:0];
        d[3] = c[2];
        add_word(OP_WRITE, IDX_DIVIDE, d, ph);
      end
      default: begin
        if (r < 85) d = $urandom_range(1, 12);
        else if (r >= 95) d = '0;
        add_word(OP_WRITE, IDX_INITIAL, d, ph);
      end
    endcase
  endtask

  task automatic gen_phase(int ph, int n);
    int start;
    int body;
    int j;
    int r;
    idx_t regs [4];
    regs = '{IDX_VECTOR, IDX_INITIAL, IDX_CURRENT, IDX_DIVIDE};
    start = word_q.size();
    hold_next = 1'b1;
    while (word_q.size() - start < n) begin
      if ($urandom_range(99) < 80) begin
        add_setup(ph, 0);
        add_setup(ph, 1);
        add_setup(ph, 2);
        body = $urandom_range(8, 40);
        for (j = 0; j < body; j++) begin
          r = $urandom_range(99);
          if (r < 70) add_word(OP_TICK, idx_t'($urandom), $urandom, ph);
          else if (r < 85) add_word(OP_READ, regs[$urandom_range(3)], $urandom, ph);
          else if (r < 90) add_setup(ph, $urandom_range(2));
          else add_word(OP_READ, idx_t'($urandom), $urandom, ph);
        end
      end else begin
        body = $urandom_range(1, 6);
        for (j = 0; j < body; j++) begin
          add_word(op_t'($urandom_range(3)), idx_t'($urandom), $urandom, ph);
        end
      end
    end
  endtask

  initial begin
    int k;
    int ph;
    timer_word_t w;
    timer_resp_t p;
    in_if.valid = 1'b0;
    in_if.op = OP_READ;
    in_if.reg_index = '0;
    in_if.write_data = '0;
    out_if.ready = 1'b0;
    t_vector = '0;
    t_masked = 1'b1;
    t_mode = MODE_ONESHOT;
    t_initial = '0;
    t_current = '0;
    t_div = '0;
    t_pre = '0;

    dir_tbl[0]  = row(OP_READ,  IDX_VECTOR,  32'h0,         1, 32'h0001_0000, 0, 8'h00);
    dir_tbl[1]  = row(OP_READ,  IDX_DIVIDE,  32'hFFFF_FFFF, 1, 32'h0,         0, 8'h00);
    dir_tbl[2]  = row(OP_READ,  IDX_CURRENT, 32'h0,         1, 32'h0,         0, 8'h00);
    dir_tbl[3]  = row(OP_READ,  6'h00,       32'h0,         1, 32'h0,         0, 8'h00);
    dir_tbl[4]  = row(OP_READ,  6'h3F,       32'h0,         1, 32'h0,         0, 8'h00);
    dir_tbl[5]  = row(OP_TICK,  IDX_VECTOR,  32'hFFFF_FFFF, 1, 32'h0,         0, 8'h00);
    dir_tbl[6]  = row(OP_NONE,  IDX_VECTOR,  32'hFFFF_FFFF, 1, 32'h0,         0, 8'h00);
    dir_tbl[7]  = row(OP_WRITE, IDX_VECTOR,  32'hFFFF_FFFF, 1, 32'h0,         0, 8'h00);
    dir_tbl[8]  = row(OP_READ,  IDX_VECTOR,  32'h0,         1, 32'h0007_00FF, 0, 8'h00);
    dir_tbl[9]  = row(OP_WRITE, IDX_VECTOR,  32'h0002_00AB, 1, 32'h0,         0, 8'h00);
    dir_tbl[10] = row(OP_WRITE, IDX_DIVIDE,  32'hFFFF_FFFF, 1, 32'h0,         0, 8'h00);
    dir_tbl[11] = row(OP_READ,  IDX_DIVIDE,  32'h0,         1, 32'h0000_000B, 0, 8'h00);
    dir_tbl[12] = row(OP_WRITE, IDX_CURRENT, 32'h0000_1234, 1, 32'h0,         0, 8'h00);
    dir_tbl[13] = row(OP_READ,  IDX_CURRENT, 32'h0,         1, 32'h0,         0, 8'h00);
    dir_tbl[14] = row(OP_WRITE, IDX_INITIAL, 32'h2,         1, 32'h0,         0, 8'h00);
    dir_tbl[15] = row(OP_TICK,  IDX_INITIAL, 32'h0,         1, 32'h0,         0, 8'h00);
    dir_tbl[16] = row(OP_TICK,  IDX_INITIAL, 32'h0,         1, 32'h0,         1, 8'hAB);
    dir_tbl[17] = row(OP_READ,  IDX_CURRENT, 32'h0,         1, 32'h2,         0, 8'h00);
    dir_tbl[18] = row(OP_WRITE, 6'h00,       32'hFFFF_FFFF, 1, 32'h0,         0, 8'h00);
    dir_tbl[19] = row(OP_WRITE, IDX_DIVIDE,  32'h0000_000A, 0, 32'h0,         0, 8'h00);
    dir_tbl[20] = row(OP_TICK,  6'h15,       32'h5555_AAAA, 0, 32'h0,         0, 8'h00);
    dir_tbl[21] = row(OP_READ,  IDX_DIVIDE,  32'h0,         0, 32'h0,         0, 8'h00);
    dir_tbl[22] = row(OP_WRITE, IDX_INITIAL, 32'hFFFF_FFFF, 1, 32'h0,         0, 8'h00);
    dir_tbl[23] = row(OP_READ,  IDX_INITIAL, 32'h0,         1, 32'hFFFF_FFFF, 0, 8'h00);
    dir_tbl[24] = row(OP_WRITE, IDX_INITIAL, 32'h0,         1, 32'h0,         0, 8'h00);
    dir_tbl[25] = row(OP_TICK,  6'h2A,       32'hAAAA_5555, 1, 32'h0,         0, 8'h00);

    foreach (dir_tbl[i]) word_q.push_back(dir_tbl[i]);
    for (ph = 0; ph < 4; ph++) gen_phase(ph, WORDS_PER_PHASE);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < word_q.size(); k++) begin
      w = word_q[k];
      cur_phase = w.phase;
      if (w.hold || coin(send_pct[w.phase])) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
        while ((w.hold && resp_q.size() != 0) || coin(send_pct[w.phase])) @(posedge clk);
      end
      in_if.valid <= 1'b1;
      in_if.op <= w.op;
      in_if.reg_index <= w.idx;
      in_if.write_data <= w.data;
      @(posedge clk);
      while (!in_if.ready) @(posedge clk);
      p = timer_step(w.op, w.idx, w.data);
      if (w.typed) begin
        p.rd = w.rd;
        p.fire = w.fire;
        p.vec = w.vec;
      end
      resp_q.push_back(p);
      case (w.op)
        OP_READ:  n_rd++;
        OP_WRITE: n_wr++;
        OP_TICK:  n_tk++;
        default:  n_other++;
      endcase
      if (p.fire) n_irq++;
    end
    in_if.valid <= 1'b0;

    while (resp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("summary: %0d reads, %0d writes, %0d ticks, %0d idle ops accepted",
             n_rd, n_wr, n_tk, n_other);
    $display("summary: %0d results checked, %0d interrupts expected, %0d mismatches",
             n_checked, n_irq, err_cnt);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  always @(posedge clk) begin : resp_check
    timer_resp_t e;
    out_if.ready <= !coin(recv_pct[cur_phase]);
    if (!rst && out_if.valid && out_if.ready) begin
      n_checked++;
      if (resp_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) begin
          $display("mismatch: unexpected word read_data %h irq_fire %b irq_vector %h",
                   out_if.read_data, out_if.irq_fire, out_if.irq_vector);
        end
      end else begin
        e = resp_q.pop_front();
        if (out_if.read_data !== e.rd || out_if.irq_fire !== e.fire ||
            out_if.irq_vector !== e.vec) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("mismatch: read_data %h/%h irq_fire %b/%b irq_vector %h/%h (exp/got)",
                     e.rd, out_if.read_data, e.fire, out_if.irq_fire,
                     e.vec, out_if.irq_vector);
          end
        end
      end
    end
  end

  initial begin
    #(LIMIT_CYCLES * 10);
    $display("timeout with %0d words still expected", resp_q.size());
    $display("tb: failure");
    $finish;
  end

endmodule
